// ===== src/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   // Default sizes
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // Width of the window size register
   localparam int CSR_WIDTH = 7;

   // Controls broadcast from the top level to every cell
   typedef struct packed {
      logic load;   // a request is taken this cycle
      logic full;   // window holds its full count, so the oldest entry leaves
   } swm_ctl_type;

endpackage

`default_nettype wire

// ===== src/swm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swm_req_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== src/swm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== src/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted window. Holds a sample and the ring slot it
// arrived in. Each request removes the oldest entry (when full) and
// inserts the new sample, using the neighbors' values and flags.
module swm_cell #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
   parameter int TAG_W        = 6
) (
   input  wire                            clock,
   input  swm_pkg::swm_ctl_type           ctl,
   input  wire                            occupied,
   input  wire        [TAG_W-1:0]         new_tag,
   input  wire        [TAG_W-1:0]         old_tag,
   input  wire signed [SAMPLE_WIDTH-1:0]  sample,
   // from the left neighbor (lower rank)
   input  wire signed [SAMPLE_WIDTH-1:0]  left_val,
   input  wire        [TAG_W-1:0]         left_tag,
   input  wire                            left_gtp,
   input  wire                            left_del,
   // from the right neighbor (higher rank)
   input  wire signed [SAMPLE_WIDTH-1:0]  right_val,
   input  wire        [TAG_W-1:0]         right_tag,
   input  wire                            right_gtraw,
   // to the neighbors
   output logic signed [SAMPLE_WIDTH-1:0] val,
   output logic        [TAG_W-1:0]        tag,
   output logic                           gtraw,
   output logic signed [SAMPLE_WIDTH-1:0] lval,
   output logic        [TAG_W-1:0]        ltag,
   output logic                           gtp,
   output logic                           del
);

   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic        [TAG_W-1:0]        tag_ff, tag_in;
   logic                           is_old;

   assign val = val_ff;
   assign tag = tag_ff;

   // Mark the oldest entry and everything above it as shifting down
   assign is_old = ctl.full && occupied && (tag_ff == old_tag);
   assign del    = left_del || is_old;

   // Empty slots compare as greater so the new sample lands at the end
   assign gtraw = !occupied || (val_ff > sample);

   // Contents after the oldest entry is dropped
   assign lval = del ? right_val   : val_ff;
   assign ltag = del ? right_tag   : tag_ff;
   assign gtp  = del ? right_gtraw : gtraw;

   // Insert: take the left entry, the new sample, or the contents after removal
   always_comb begin
      if (gtp && left_gtp) begin
         val_in = left_val;
         tag_in = left_tag;
      end else if (gtp) begin
         val_in = sample;
         tag_in = new_tag;
      end else begin
         val_in = lval;
         tag_in = ltag;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         val_ff <= val_in;
         tag_ff <= tag_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/sliding_window_median_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload               Meaning
// req_chan  in   sample [SW-1:0] s     next sample entering the window
// rsp_chan  out  median [SW-1:0] s     lower median of the full window
// csr_*     in   csr_wdata [6:0]       window size, restarts the fill
//
// One request per cycle while req_chan.ready is high. The row of cells updates
// at the accept edge; the median is picked from the first half of the row into
// the output register when it is free. The cell row holds one pending result
// while the output register is stalled. Reset is synchronous; it clears the
// counters and valid flags, sets the window size to one, and leaves the cells.
module sliding_window_median_core #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   swm_req_if.sink                          req_chan,
   swm_rsp_if.source                        rsp_chan,
   input  wire                              csr_we,
   input  wire [swm_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int TAG_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int MED_N = (WINDOW_MAX + 1) / 2;
   localparam int MED_W = (MED_N > 1) ? $clog2(MED_N) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] win_ff, win_in;
   logic [TAG_W-1:0] old_ff, old_in;
   logic [MED_W-1:0] med_ff, med_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff, rsp_median_in;

   logic             accept, full, take, produce;
   logic [CNT_W-1:0] count_inc, old_inc, eff_win;
   logic [TAG_W-1:0] new_tag;
   swm_pkg::swm_ctl_type ctl;

   logic signed [SAMPLE_WIDTH-1:0] c_val  [WINDOW_MAX];
   logic        [TAG_W-1:0]        c_tag  [WINDOW_MAX];
   logic                           c_gtraw[WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] c_lval [WINDOW_MAX];
   logic        [TAG_W-1:0]        c_ltag [WINDOW_MAX];
   logic                           c_gtp  [WINDOW_MAX];
   logic                           c_del  [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] med_pick;

   // Handshake
   assign take             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = !pend_ff || take;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.median  = rsp_median_ff;

   // Window bookkeeping
   assign full      = (count_ff >= win_ff);
   assign count_inc = count_ff + CNT_W'(1);
   assign old_inc   = CNT_W'(old_ff) + CNT_W'(1);
   assign new_tag   = full ? old_ff : count_ff[TAG_W-1:0];
   assign produce   = full || (count_inc >= win_ff);
   assign ctl.load  = accept;
   assign ctl.full  = full;

   // Clamp the written size to 1..WINDOW_MAX
   always_comb begin
      if (csr_wdata == '0) begin
         eff_win = CNT_W'(1);
      end else if (int'(csr_wdata) > WINDOW_MAX) begin
         eff_win = CNT_W'(WINDOW_MAX);
      end else begin
         eff_win = CNT_W'(csr_wdata);
      end
   end

   always_comb begin
      count_in = count_ff;
      old_in   = old_ff;
      win_in   = win_ff;
      med_in   = med_ff;
      if (csr_we) begin
         win_in   = eff_win;
         med_in   = MED_W'((eff_win - CNT_W'(1)) >> 1);
         count_in = '0;
         old_in   = '0;
      end else if (accept) begin
         if (full) begin
            old_in = (old_inc >= win_ff) ? '0 : old_inc[TAG_W-1:0];
         end else begin
            count_in = count_inc;
            old_in   = '0;
         end
      end
   end

   // Pending result in the cells, then the output register
   always_comb begin
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && take) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = med_pick;
         pend_in       = 1'b0;
      end
      if (accept) begin
         pend_in = produce;
      end
      if (csr_we) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         win_ff       <= CNT_W'(1);
         old_ff       <= '0;
         med_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         win_ff       <= win_in;
         old_ff       <= old_in;
         med_ff       <= med_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   // Row of sorted cells, lowest rank on the left
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] lv, rv;
      logic        [TAG_W-1:0]        lt, rt;
      logic                           lg, ld, rg;

      if (i == 0) begin : g_first
         assign lv = '0;
         assign lt = '0;
         assign lg = 1'b0;
         assign ld = 1'b0;
      end else begin : g_mid
         assign lv = c_lval[i-1];
         assign lt = c_ltag[i-1];
         assign lg = c_gtp[i-1];
         assign ld = c_del[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign rv = '0;
         assign rt = '0;
         assign rg = 1'b1;
      end else begin : g_inner
         assign rv = c_val[i+1];
         assign rt = c_tag[i+1];
         assign rg = c_gtraw[i+1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .TAG_W        (TAG_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (CNT_W'(i) < count_ff),
         .new_tag     (new_tag),
         .old_tag     (old_ff),
         .sample      (req_chan.sample),
         .left_val    (lv),
         .left_tag    (lt),
         .left_gtp    (lg),
         .left_del    (ld),
         .right_val   (rv),
         .right_tag   (rt),
         .right_gtraw (rg),
         .val         (c_val[i]),
         .tag         (c_tag[i]),
         .gtraw       (c_gtraw[i]),
         .lval        (c_lval[i]),
         .ltag        (c_ltag[i]),
         .gtp         (c_gtp[i]),
         .del         (c_del[i])
      );
   end

   // Pick the median rank; it always lies in the lower half of the row
   always_comb begin
      med_pick = '0;
      for (int i = 0; i < MED_N; i++) begin
         if (MED_W'(i) == med_ff) begin
            med_pick = med_pick | c_val[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/swm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_checker #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire [SAMPLE_WIDTH-1:0] rsp_median,
   input wire                    csr_we
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("response changed while stalled");

   // Keep taking requests while the output is free
   a_ready_free: assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output");

   // A fresh response comes from an accepted request via the pending flag
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // Drop any response on a size write and out of reset
   a_rsp_clear: assert property (@(posedge clock)
      csr_we || reset |=> !rsp_valid)
      else $error("response after reset or size write");

endmodule

bind sliding_window_median_core swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_median (rsp_chan.median),
   .csr_we     (csr_we)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int SW         = swm_pkg::SAMPLE_WIDTH_DEF;
   localparam int WMAX       = swm_pkg::WINDOW_MAX_DEF;
   localparam int ITEM_GOAL  = 1150;
   localparam int QUIET_MAX  = 1000;
   localparam int DRAIN_PAD  = 4;

   typedef logic signed [SW-1:0] sample_type;
   typedef logic [swm_pkg::CSR_WIDTH-1:0] window_type;

   localparam sample_type S_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam sample_type S_MAX = {1'b0, {(SW-1){1'b1}}};

   // Tracks the window and the ordered copy, queues the medians still owed
   class median_tracker;
      window_type  window_reg;
      sample_type  ring[WMAX];
      sample_type  ordered[WMAX];
      int unsigned held;
      int unsigned oldest;
      sample_type  pending_medians[$];
      int unsigned mismatches;

      function new();
         window_reg = 1;
         held       = 0;
         oldest     = 0;
         mismatches = 0;
      endfunction

      // Clamp the register to the usable window length
      function int unsigned span();
         if (window_reg == 0) return 1;
         if (window_reg > WMAX) return WMAX;
         return window_reg;
      endfunction

      function void set_window(window_type v);
         window_reg = v;
         held       = 0;
         oldest     = 0;
      endfunction

      // Remove one copy of v from the first n ordered entries
      function void drop_value(sample_type v, int unsigned n);
         int unsigned p;
         p = n - 1;
         for (int unsigned i = 0; i < n; i++) begin
            if (ordered[i] == v) begin
               p = i;
               break;
            end
         end
         for (int unsigned i = p; i + 1 < n; i++) ordered[i] = ordered[i + 1];
      endfunction

      // Insert v into the first n ordered entries, behind any equal ones
      function void place_value(sample_type v, int unsigned n);
         int unsigned i;
         i = n;
         while (i > 0 && ordered[i - 1] > v) begin
            ordered[i] = ordered[i - 1];
            i--;
         end
         ordered[i] = v;
      endfunction

      function void take_sample(sample_type s);
         int unsigned k;
         int unsigned slot;
         sample_type  old;
         k = span();
         if (held >= k) begin
            // Evict the oldest sample, then insert the new one
            slot       = (oldest < k) ? oldest : 0;
            old        = ring[slot];
            ring[slot] = s;
            oldest     = (slot + 1 >= k) ? 0 : slot + 1;
            drop_value(old, k);
            place_value(s, k - 1);
         end else begin
            // Still filling: no median until the window is full
            ring[held] = s;
            place_value(s, held);
            held++;
            if (held < k) return;
            oldest = 0;
         end
         pending_medians = {pending_medians, ordered[(k - 1) / 2]};
      endfunction

      function void check_median(sample_type got);
         sample_type want;
         if (pending_medians.size() == 0) begin
            $error("unexpected response: median %0d with nothing pending", got);
            mismatches++;
            return;
         end
         want = pending_medians[0];
         pending_medians.delete(0);
         if (got !== want) begin
            $error("median mismatch: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction

      function bit drained();
         return pending_medians.size() == 0;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   window_type csr_wdata;

   swm_req_if #(.SAMPLE_WIDTH(SW)) req_if ();
   swm_rsp_if #(.SAMPLE_WIDTH(SW)) rsp_if ();

   median_tracker tracker = new();

   int unsigned burst_left = 0;
   int unsigned sent       = 0;

   sliding_window_median_core #(
      .WINDOW_MAX   (WMAX),
      .SAMPLE_WIDTH (SW)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side, switching among four ready patterns as ready_cycle advances
   int unsigned ready_cycle = 0;
   always @(posedge clock) begin
      case ((ready_cycle / 256) % 4)
         0: begin
            rsp_if.ready <= 1'b1;
         end
         1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_if.ready <= (ready_cycle % 7) >= 2;
         end
         default: begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
         end
      endcase
      ready_cycle++;
   end

   // Observe handshakes and register writes; guard against a hang
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.set_window(csr_wdata);
         if (req_if.valid && req_if.ready) tracker.take_sample(req_if.sample);
         if (rsp_if.valid && rsp_if.ready) tracker.check_median(rsp_if.median);
         if (csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_MAX) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Hold off requests until every owed median has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (!tracker.drained()) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_window(input window_type v);
      wait_drained();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Offer one request, with bursts and gaps, and wait for its acceptance
   task automatic send_sample(input sample_type s);
      if ($urandom_range(0, 79) == 0) wait_drained();
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'({$urandom, $urandom});
         4, 5, 6:    return sample_type'($urandom_range(0, 8)) - 4;
         7:          return S_MIN + sample_type'($urandom_range(0, 3));
         8:          return S_MAX - sample_type'($urandom_range(0, 3));
         default:    return $urandom_range(0, 1) ? S_MIN : S_MAX;
      endcase
   endfunction

   function automatic window_type pick_window();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return window_type'($urandom_range(1, 12));
         6:                return window_type'($urandom_range(13, 63));
         7:                return window_type'(WMAX);
         8:                return window_type'($urandom_range(WMAX + 1, 127));
         default:          return '0;
      endcase
   endfunction

   initial begin
      int unsigned k;
      int unsigned n;
      int unsigned phase;
      window_type  w;

      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Window of one out of reset: every sample is its own median
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample('0);
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));

      // Window size zero behaves as one
      write_window('0);
      send_sample(sample_type'(7));
      send_sample(S_MIN);

      // Window of two reports the smaller sample
      write_window(window_type'(2));
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample(sample_type'(5));

      // Window of three with repeated values evicted and reinserted
      write_window(window_type'(3));
      send_sample(sample_type'(4));
      send_sample(sample_type'(4));
      send_sample(sample_type'(4));
      send_sample(sample_type'(-2));
      send_sample(sample_type'(4));
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(sample_type'(4));

      // Random phases: saturating and full windows first, then mostly small
      phase = 0;
      while (sent < ITEM_GOAL) begin
         if (phase == 0) w = window_type'(127);
         else if (phase == 1) w = window_type'(WMAX);
         else w = pick_window();
         write_window(w);
         k = (w == 0) ? 1 : ((w > WMAX) ? WMAX : w);
         n = k + $urandom_range(0, 40);
         repeat (n) send_sample(pick_sample());
         phase++;
      end

      wait_drained();
      if (tracker.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
